// ----- hw/rtl/ski_pkg.sv -----
// ----------------------------------------------------------------------------
// ski_pkg
// Shared types, codes and the microcode table of the sorted key index.
// ----------------------------------------------------------------------------
package ski_pkg;

  localparam int KEY_BITS     = 32;
  localparam int POS_BITS     = 6;
  localparam int STATUS_BITS  = 3;
  localparam int CAPACITY_DEF = 64;

  // request operations
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd4;

  typedef logic [3:0] step_t;

  // program steps
  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_PROBE_MID = 4'd1;
  localparam step_t S_NARROW    = 4'd2;
  localparam step_t S_PROBE_LO  = 4'd3;
  localparam step_t S_DECIDE    = 4'd4;
  localparam step_t S_SHIFT_RD  = 4'd5;
  localparam step_t S_SHIFT_WR  = 4'd6;
  localparam step_t S_STORE     = 4'd7;
  localparam step_t S_RESPOND   = 4'd8;

  typedef enum logic [2:0] {
    A_ACCEPT,
    A_PROBE_MID,
    A_NARROW,
    A_PROBE_LO,
    A_DECIDE,
    A_SHIFT_RD,
    A_SHIFT_WR,
    A_STORE
  } act_t;

  typedef enum logic [1:0] {
    W_NONE,
    W_REQ,
    W_RSP
  } wait_t;

  typedef enum logic [2:0] {
    J_NEVER,
    J_ALWAYS,
    J_SEARCH_DONE,
    J_NO_SHIFT,
    J_SHIFT_DONE,
    J_SHIFT_MORE
  } jump_t;

  typedef struct packed {
    act_t  act;
    logic  respond;
    wait_t wait_c;
    jump_t jump_c;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [POS_BITS-1:0] pos;
  } entry_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    unique case (step)
      S_IDLE:      uc = '{A_ACCEPT,    1'b0, W_REQ,  J_NEVER,       S_IDLE};
      S_PROBE_MID: uc = '{A_PROBE_MID, 1'b0, W_NONE, J_SEARCH_DONE, S_PROBE_LO};
      S_NARROW:    uc = '{A_NARROW,    1'b0, W_NONE, J_ALWAYS,      S_PROBE_MID};
      S_PROBE_LO:  uc = '{A_PROBE_LO,  1'b0, W_NONE, J_NEVER,       S_IDLE};
      S_DECIDE:    uc = '{A_DECIDE,    1'b0, W_NONE, J_NO_SHIFT,    S_RESPOND};
      S_SHIFT_RD:  uc = '{A_SHIFT_RD,  1'b0, W_NONE, J_SHIFT_DONE,  S_STORE};
      S_SHIFT_WR:  uc = '{A_SHIFT_WR,  1'b0, W_NONE, J_SHIFT_MORE,  S_SHIFT_WR};
      S_STORE:     uc = '{A_STORE,     1'b0, W_NONE, J_NEVER,       S_IDLE};
      S_RESPOND:   uc = '{A_PROBE_LO,  1'b1, W_RSP,  J_ALWAYS,      S_IDLE};
      default:     uc = '{A_PROBE_LO,  1'b0, W_NONE, J_ALWAYS,      S_IDLE};
    endcase
    return uc;
  endfunction

endpackage

// ----- hw/rtl/ski_req_if.sv -----
// ----------------------------------------------------------------------------
// ski_req_if
// Request channel of the sorted key index: operation and key.
// ----------------------------------------------------------------------------
interface ski_req_if
  import ski_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [KEY_BITS-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

// ----- hw/rtl/ski_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ski_rsp_if
// Result channel of the sorted key index: status and record position.
// ----------------------------------------------------------------------------
interface ski_rsp_if
  import ski_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [POS_BITS-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

// ----- hw/rtl/sorted_key_index.sv -----
// ----------------------------------------------------------------------------
// sorted_key_index
// Sorted key table with binary search lookup and shifting insert.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (op, key); each request gives exactly one
// result on rsp (status, position), in request order. Insert (op 0) adds a
// new key with position equal to the current entry count, or answers
// duplicate / table full. Lookup (op 1) answers found with the stored
// position, or not found.
// One request is worked on at a time by a small microcode sequencer over a
// single-port-read, single-port-write table memory with registered read data.
// Work from a request being taken to its result being takeable:
//   lookup: a binary search, each search step (probe, narrow) waiting on
//   the memory read, then a probe of the found slot and a decision
//   insert: the same, then the larger entries are moved up, one per cycle,
//   and the new key is stored
// The next request is taken in the cycle the result first shows; the longest
// request is a new smallest key into 63 entries.
// Reset empties the table (count to zero); the memory is not cleared.
// When the receiver stalls, the result stays in the output register; the
// next request is still taken and worked on, but its result waits until the
// held one has gone.
// ----------------------------------------------------------------------------
module sorted_key_index
  import ski_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  ski_req_if.sink   req,
  ski_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [KEY_BITS-1:0] SIGN_FLIP = {1'b1, {(KEY_BITS-1){1'b0}}};

  entry_t mem [CAPACITY];
  entry_t rd_q;
  logic   [AW-1:0] rd_addr;
  logic            mem_we;
  logic   [AW-1:0] mem_wa;
  entry_t          mem_wd;

  step_t  pc, pc_next;
  ucode_t uc;
  logic   stall;
  logic   jump;

  logic                   op, op_next;
  logic [KEY_BITS-1:0]    okey, okey_next;
  logic [CW-1:0]          lo, lo_next;
  logic [CW-1:0]          hi, hi_next;
  logic [CW-1:0]          mid, mid_next;
  logic [CW-1:0]          j, j_next;
  logic [CW-1:0]          count, count_next;
  logic [STATUS_BITS-1:0] status_q, status_next;
  logic [POS_BITS-1:0]    pos_q, pos_next;

  logic [CW-1:0] mid_w;
  logic          hit;
  logic          full;
  logic          need_shift;

  logic                   rsp_valid;
  logic [STATUS_BITS-1:0] rsp_status;
  logic [POS_BITS-1:0]    rsp_position;
  logic                   respond;

  assign uc     = ucode_rom(pc);
  assign mid_w  = CW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign hit    = (lo < count) && (rd_q.key == okey);
  assign full   = (count == CW'(CAPACITY));
  assign need_shift = (op == OP_INSERT) && !hit && !full;

  // sequencer: wait, jump and step
  always_comb begin
    unique case (uc.wait_c)
      W_REQ:   stall = !req.valid;
      W_RSP:   stall = rsp_valid && !rsp.ready;
      default: stall = 1'b0;
    endcase
    unique case (uc.jump_c)
      J_ALWAYS:      jump = 1'b1;
      J_SEARCH_DONE: jump = !(lo < hi);
      J_NO_SHIFT:    jump = !need_shift;
      J_SHIFT_DONE:  jump = !(j > lo);
      J_SHIFT_MORE:  jump = ({1'b0, j} > ({1'b0, lo} + (CW+1)'(1)));
      default:       jump = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = uc.target;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  assign req.ready = (uc.act == A_ACCEPT);
  assign respond   = uc.respond && !stall;

  // datapath decode of the control word
  always_comb begin
    op_next     = op;
    okey_next   = okey;
    lo_next     = lo;
    hi_next     = hi;
    mid_next    = mid;
    j_next      = j;
    count_next  = count;
    status_next = status_q;
    pos_next    = pos_q;
    rd_addr     = lo[AW-1:0];
    mem_we      = 1'b0;
    mem_wa      = lo[AW-1:0];
    mem_wd      = rd_q;
    if (!stall) begin
      unique case (uc.act)
        A_ACCEPT: begin
          op_next   = req.op;
          okey_next = req.key ^ SIGN_FLIP;
          lo_next   = '0;
          hi_next   = count;
        end
        A_PROBE_MID: begin
          rd_addr  = mid_w[AW-1:0];
          mid_next = mid_w;
        end
        A_NARROW: begin
          if (rd_q.key < okey) begin
            lo_next = mid + CW'(1);
          end else begin
            hi_next = mid;
          end
        end
        A_PROBE_LO: begin
          rd_addr = lo[AW-1:0];
        end
        A_DECIDE: begin
          j_next   = count;
          pos_next = '0;
          if (op == OP_LOOKUP) begin
            status_next = hit ? ST_FOUND : ST_NOT_FOUND;
            if (hit) begin
              pos_next = rd_q.pos;
            end
          end else if (hit) begin
            status_next = ST_DUPLICATE;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            status_next = ST_INSERTED;
            pos_next    = POS_BITS'(count);
          end
        end
        A_SHIFT_RD: begin
          rd_addr = AW'(j - CW'(1));
        end
        A_SHIFT_WR: begin
          // move one entry up and fetch the one below it
          mem_we  = 1'b1;
          mem_wa  = j[AW-1:0];
          mem_wd  = rd_q;
          j_next  = j - CW'(1);
          rd_addr = AW'(j - CW'(2));
        end
        A_STORE: begin
          mem_we     = 1'b1;
          mem_wa     = lo[AW-1:0];
          mem_wd     = '{key: okey, pos: pos_q};
          count_next = count + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    okey     <= okey_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    j        <= j_next;
    status_q <= status_next;
    pos_q    <= pos_next;
    if (respond) begin
      rsp_status   <= status_q;
      rsp_position <= pos_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      pc    <= pc_next;
      count <= count_next;
      if (respond) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.status   = rsp_status;
  assign rsp.position = rsp_position;

  // table never holds more than its capacity
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // the table is written only while moving entries or storing the new one
  a_write_steps : assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (pc == S_SHIFT_WR || pc == S_STORE))
    else $error("table written outside insert steps");

  // shifting only happens for an insert that was decided as inserted
  a_shift_inserted : assert property (@(posedge clk) disable iff (rst)
    (pc == S_SHIFT_RD || pc == S_SHIFT_WR || pc == S_STORE) |->
      (status_q == ST_INSERTED && op == OP_INSERT))
    else $error("shift without an accepted insert");

  // one request at a time: no new request right after one is taken
  a_one_at_a_time : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");

  // count only grows by the store step
  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(pc) == S_STORE && count == $past(count) + CW'(1)))
    else $error("count changed outside store");

endmodule
